// ===== sv/assert_macros.svh =====
// assertion helpers used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that must hold at every clock edge outside reset
`define EVAD_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// an implication checked at the same clock edge
`define EVAD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/evad_pkg.sv =====
`default_nettype none
package evad_pkg;

   localparam int MAX_FRAME  = 8192;
   localparam int COUNT_W    = 14;
   localparam int SUM_W      = 44;
   localparam int SQ_W       = 31;
   localparam int TIME_W     = 32;
   localparam int THR_W      = 31;
   localparam int MS_W       = 20;
   localparam int PROD_W     = TIME_W + COUNT_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   // item kinds
   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_BUTTON = 2'd2;
   localparam logic [1:0] FUNC_REPLY  = 2'd3;

   // session modes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_ARMED = 2'd1;
   localparam logic [1:0] MODE_REC   = 2'd2;
   localparam logic [1:0] MODE_WAIT  = 2'd3;

   // event codes
   localparam logic [3:0] EV_QUIET       = 4'd0;
   localparam logic [3:0] EV_SPEECH      = 4'd1;
   localparam logic [3:0] EV_RECORDING   = 4'd2;
   localparam logic [3:0] EV_END_SILENCE = 4'd3;
   localparam logic [3:0] EV_END_LENGTH  = 4'd4;
   localparam logic [3:0] EV_SLEEP       = 4'd5;
   localparam logic [3:0] EV_OPENED      = 4'd6;
   localparam logic [3:0] EV_CLOSED      = 4'd7;
   localparam logic [3:0] EV_RESUMED     = 4'd8;

   // register indexes
   localparam logic [1:0] REG_THRESHOLD   = 2'd0;
   localparam logic [1:0] REG_MAX_SEGMENT = 2'd1;
   localparam logic [1:0] REG_MAX_SILENCE = 2'd2;
   localparam logic [1:0] REG_REST_LIMIT  = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage
`default_nettype wire

// ===== sv/evad_front.sv =====
`default_nettype none
module evad_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [15:0]               req_tdata,  // sample
   input  wire logic [1:0]                req_tuser,  // func
   input  wire logic                      req_tlast,  // last_in_frame
   input  wire evad_pkg::fifo_status_type fifo_status,
   output logic                           push,
   output evad_pkg::entry_type            push_entry
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [1:0]                    s1_func_ff, s1_func_in;
   logic [evad_pkg::SQ_W-1:0]     s1_sq_ff, s1_sq_in;
   logic                          s1_last_ff, s1_last_in;
   logic [evad_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [evad_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic signed [31:0]            sq_full;
   logic                          accept, need_push, advance, room, is_sample;
   logic [evad_pkg::SUM_W-1:0]    sum_acc;
   logic [evad_pkg::COUNT_W-1:0]  count_acc;

   assign sq_full   = 32'($signed(req_tdata)) * 32'($signed(req_tdata));
   assign accept    = req_tvalid && req_tready;
   assign is_sample = (s1_func_ff == evad_pkg::FUNC_SAMPLE);
   assign need_push = s1_valid_ff && (!is_sample || s1_last_ff);
   assign advance   = s1_valid_ff && !(need_push && fifo_status.full);
   assign req_tready = !s1_valid_ff || advance;

   // frame saturates at the maximum count, extra samples dropped
   assign room      = (count_ff < evad_pkg::COUNT_W'(evad_pkg::MAX_FRAME));
   assign sum_acc   = room ? sum_ff + evad_pkg::SUM_W'(s1_sq_ff) : sum_ff;
   assign count_acc = room ? count_ff + evad_pkg::COUNT_W'(1) : count_ff;

   assign push             = need_push && advance;
   assign push_entry.func  = s1_func_ff;
   assign push_entry.sum   = is_sample ? sum_acc : '0;
   assign push_entry.count = is_sample ? count_acc : '0;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_func_in  = s1_func_ff;
      s1_sq_in    = s1_sq_ff;
      s1_last_in  = s1_last_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      if (advance && is_sample) begin
         if (s1_last_ff) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_acc;
            count_in = count_acc;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_func_in  = req_tuser;
         s1_sq_in    = sq_full[evad_pkg::SQ_W-1:0];
         s1_last_in  = req_tlast;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
      s1_func_ff <= s1_func_in;
      s1_sq_ff   <= s1_sq_in;
      s1_last_ff <= s1_last_in;
   end

endmodule
`default_nettype wire

// ===== sv/evad_fifo.sv =====
`default_nettype none
module evad_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire evad_pkg::entry_type   push_entry,
   input  wire logic                  pop,
   output evad_pkg::entry_type        head,
   output evad_pkg::fifo_status_type  status
);

   evad_pkg::entry_type             mem [evad_pkg::FIFO_DEPTH];
   logic [evad_pkg::FIFO_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [evad_pkg::FIFO_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [evad_pkg::FIFO_AW:0]      fill_ff, fill_in;

   assign head         = mem[rd_ptr_ff];
   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == (evad_pkg::FIFO_AW + 1)'(evad_pkg::FIFO_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + evad_pkg::FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + evad_pkg::FIFO_AW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (evad_pkg::FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (evad_pkg::FIFO_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== sv/evad_back.sv =====
`default_nettype none
module evad_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [30:0]               csr_wr_data,
   input  wire evad_pkg::entry_type       head,
   input  wire evad_pkg::fifo_status_type fifo_status,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata   // event_res, loud, mode, pad
);

   localparam logic [1:0] ST_FETCH = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_DEC   = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [evad_pkg::THR_W-1:0]      thr_ff, thr_in;
   logic [evad_pkg::MS_W-1:0]       seg_lim_ff, seg_lim_in;
   logic [evad_pkg::MS_W-1:0]       sil_lim_ff, sil_lim_in;
   logic [evad_pkg::MS_W-1:0]       rest_lim_ff, rest_lim_in;
   logic [1:0]                      mode_ff, mode_in;
   logic [evad_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [evad_pkg::TIME_W-1:0]     rest_start_ff, rest_start_in;
   logic [evad_pkg::TIME_W-1:0]     seg_start_ff, seg_start_in;
   logic [evad_pkg::TIME_W-1:0]     last_loud_ff, last_loud_in;
   logic [evad_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [evad_pkg::COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [evad_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic                            out_valid_ff, out_valid_in;
   logic [3:0]                      out_ev_ff, out_ev_in;
   logic                            out_loud_ff, out_loud_in;
   logic [1:0]                      out_mode_ff, out_mode_in;

   logic                            out_free, load, loud;
   logic [evad_pkg::TIME_W-1:0]     thr_inc;
   logic [evad_pkg::TIME_W-1:0]     rest_elapsed, seg_elapsed, sil_elapsed;

   assign out_free     = !out_valid_ff || rsp_tready;
   assign thr_inc      = {1'b0, thr_ff} + evad_pkg::TIME_W'(1);
   assign rest_elapsed = now_ff - rest_start_ff;
   assign seg_elapsed  = now_ff - seg_start_ff;
   assign sil_elapsed  = now_ff - last_loud_ff;
   // mean > thr  <=>  sum >= (thr + 1) * count
   assign loud = (cnt_ff != '0) &&
                 ({{(evad_pkg::PROD_W - evad_pkg::SUM_W){1'b0}}, sum_ff} >= prod_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_mode_ff, out_loud_ff, out_ev_ff};

   always_comb begin
      state_in      = state_ff;
      thr_in        = thr_ff;
      seg_lim_in    = seg_lim_ff;
      sil_lim_in    = sil_lim_ff;
      rest_lim_in   = rest_lim_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      rest_start_in = rest_start_ff;
      seg_start_in  = seg_start_ff;
      last_loud_in  = last_loud_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      prod_in       = evad_pkg::PROD_W'(thr_inc) * evad_pkg::PROD_W'(cnt_ff);
      out_ev_in     = out_ev_ff;
      out_loud_in   = out_loud_ff;
      out_mode_in   = out_mode_ff;
      pop           = 1'b0;
      load          = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            evad_pkg::REG_THRESHOLD:   thr_in      = csr_wr_data;
            evad_pkg::REG_MAX_SEGMENT: seg_lim_in  = csr_wr_data[evad_pkg::MS_W-1:0];
            evad_pkg::REG_MAX_SILENCE: sil_lim_in  = csr_wr_data[evad_pkg::MS_W-1:0];
            evad_pkg::REG_REST_LIMIT:  rest_lim_in = csr_wr_data[evad_pkg::MS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_FETCH: begin
            if (!fifo_status.empty) begin
               case (head.func)
                  evad_pkg::FUNC_TICK: begin
                     pop    = 1'b1;
                     now_in = now_ff + evad_pkg::TIME_W'(1);
                  end
                  evad_pkg::FUNC_SAMPLE: begin
                     pop      = 1'b1;
                     sum_in   = head.sum;
                     cnt_in   = head.count;
                     state_in = ST_MUL;
                  end
                  default: begin
                     if (out_free) begin
                        pop         = 1'b1;
                        load        = 1'b1;
                        out_ev_in   = evad_pkg::EV_QUIET;
                        out_loud_in = 1'b0;
                        if (head.func == evad_pkg::FUNC_BUTTON) begin
                           if (mode_ff == evad_pkg::MODE_IDLE) begin
                              mode_in       = evad_pkg::MODE_ARMED;
                              rest_start_in = now_ff;
                              out_ev_in     = evad_pkg::EV_OPENED;
                           end else if (mode_ff == evad_pkg::MODE_ARMED) begin
                              mode_in   = evad_pkg::MODE_IDLE;
                              out_ev_in = evad_pkg::EV_CLOSED;
                           end
                        end else if (mode_ff == evad_pkg::MODE_WAIT) begin
                           mode_in       = evad_pkg::MODE_ARMED;
                           rest_start_in = now_ff;
                           out_ev_in     = evad_pkg::EV_RESUMED;
                        end
                        out_mode_in = mode_in;
                     end
                  end
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            prod_in = prod_ff;
            if (out_free) begin
               load        = 1'b1;
               state_in    = ST_FETCH;
               out_ev_in   = evad_pkg::EV_QUIET;
               out_loud_in = loud;
               case (mode_ff)
                  evad_pkg::MODE_ARMED: begin
                     if (loud) begin
                        mode_in      = evad_pkg::MODE_REC;
                        seg_start_in = now_ff;
                        last_loud_in = now_ff;
                        out_ev_in    = evad_pkg::EV_SPEECH;
                     end else if (rest_elapsed > evad_pkg::TIME_W'(rest_lim_ff)) begin
                        mode_in   = evad_pkg::MODE_IDLE;
                        out_ev_in = evad_pkg::EV_SLEEP;
                     end
                  end
                  evad_pkg::MODE_REC: begin
                     out_ev_in = evad_pkg::EV_RECORDING;
                     if (loud) begin
                        last_loud_in = now_ff;
                        if (seg_elapsed >= evad_pkg::TIME_W'(seg_lim_ff)) begin
                           mode_in   = evad_pkg::MODE_WAIT;
                           out_ev_in = evad_pkg::EV_END_LENGTH;
                        end
                     end else if (sil_elapsed > evad_pkg::TIME_W'(sil_lim_ff)) begin
                        mode_in   = evad_pkg::MODE_WAIT;
                        out_ev_in = evad_pkg::EV_END_SILENCE;
                     end
                  end
                  default: ;
               endcase
               out_mode_in = mode_in;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FETCH;
         thr_ff        <= evad_pkg::THR_W'(2000);
         seg_lim_ff    <= evad_pkg::MS_W'(10000);
         sil_lim_ff    <= evad_pkg::MS_W'(1000);
         rest_lim_ff   <= evad_pkg::MS_W'(30000);
         mode_ff       <= evad_pkg::MODE_IDLE;
         now_ff        <= '0;
         rest_start_ff <= '0;
         seg_start_ff  <= '0;
         last_loud_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         seg_lim_ff    <= seg_lim_in;
         sil_lim_ff    <= sil_lim_in;
         rest_lim_ff   <= rest_lim_in;
         mode_ff       <= mode_in;
         now_ff        <= now_in;
         rest_start_ff <= rest_start_in;
         seg_start_ff  <= seg_start_in;
         last_loud_ff  <= last_loud_in;
         out_valid_ff  <= out_valid_in;
      end
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      out_ev_ff   <= out_ev_in;
      out_loud_ff <= out_loud_in;
      out_mode_ff <= out_mode_in;
   end

endmodule
`default_nettype wire

// ===== sv/energy_vad_endpoint_detector_unit.sv =====
// channel  | direction | signals                              | contents
// req      | in        | req_tvalid/tready/tdata/tuser/tlast  | sample, func, last_in_frame
// rsp      | out       | rsp_tvalid/tready/tdata              | event_res, loud, mode
// csr      | in        | csr_wr_en/index/wr_data              | register writes, no read-back
//
// samples and ticks are taken one per cycle unless a push waits on a full queue; the front squares and sums each sample
// a frame end passes three steps in the back: fetch, threshold multiply, session decision
// button and reply-done items are handled in the fetch step alone, ticks likewise with no result
// synchronous active-high reset, no clearing pass
// a stalled rsp side fills the four-entry queue, after which req_tready drops
`default_nettype none
`include "assert_macros.svh"
module energy_vad_endpoint_detector_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // sample
   input  wire logic [1:0]  req_tuser,   // func
   input  wire logic        req_tlast,   // last_in_frame
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // event_res[3:0], loud[4], mode[6:5], zero pad[7]
   // configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wr_data
);

   // front to queue
   logic                       push;
   evad_pkg::entry_type        push_entry;
   // queue to back
   logic                       pop;
   evad_pkg::entry_type        head;
   evad_pkg::fifo_status_type  fifo_status;

   // front: squares samples, sums the frame, queues frame ends and events
   evad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // short queue decoupling the two halves
   evad_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   // back: millisecond clock, loudness decision, session machine, output register
   evad_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // queue never overflows or underflows
   `EVAD_ASSERT_IMPL(a_no_push_full, push, !fifo_status.full)
   `EVAD_ASSERT_IMPL(a_no_pop_empty, pop, !fifo_status.empty)
   // loud only appears on frame-end events
   `EVAD_ASSERT_IMPL(a_loud_frame_only, rsp_tvalid && rsp_tdata[4],
      rsp_tdata[3:0] <= evad_pkg::EV_SLEEP)
   // an opened session is armed
   `EVAD_ASSERT_IMPL(a_opened_armed, rsp_tvalid && (rsp_tdata[3:0] == evad_pkg::EV_OPENED),
      rsp_tdata[6:5] == evad_pkg::MODE_ARMED)

endmodule
`default_nettype wire

// ===== tb/energy_vad_endpoint_detector_unit_tb.sv =====
module energy_vad_endpoint_detector_unit_tb;

   // run limits
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 12;    // covers the back stage plus a margin
   localparam int HOLD_CYCLES  = 300;   // long rsp stall for the backpressure test

   // clock and reset
   logic clock = 1'b0;
   logic reset;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // dut ports
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // sample
   logic [1:0]  req_tuser;    // func
   logic        req_tlast;    // last_in_frame
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;    // event_res[3:0], loud[4], mode[6:5], zero pad[7]
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [30:0] csr_wr_data;

   energy_vad_endpoint_detector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // one result transfer as the session machine reports it
   typedef struct packed {
      logic [3:0] ev;
      logic       loud;
      logic [1:0] mode;
   } vad_result_type;

   vad_result_type pending_events[$];   // predicted results, oldest first
   vad_result_type head_event;

   // idle pressure on both sides, in percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   int failures   = 0;
   int items_sent = 0;
   int cycle_count = 0;

   // long receiver stall: the test bumps hold_requests, the rsp process counts it out
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // predictor copy of the block state and registers
   logic [1:0]  sess_mode;
   logic [31:0] now_ms;
   logic [31:0] rest_from_ms;
   logic [31:0] seg_from_ms;
   logic [31:0] loud_at_ms;
   logic [43:0] acc_energy;
   logic [13:0] acc_count;
   logic [30:0] cfg_threshold;
   logic [19:0] cfg_max_segment;
   logic [19:0] cfg_max_silence;
   logic [19:0] cfg_rest_limit;

   // ---------------------------------------------------------------
   // predictor: advance the session model by one accepted item and
   // queue the result transfer that it causes, if any
   // ---------------------------------------------------------------
   task automatic predict_session_event(input logic [1:0] func, input logic [15:0] smp,
                                        input logic last);
      logic [15:0]    mag;
      logic [63:0]    mean;
      logic           has_result;
      vad_result_type res;
      has_result = 1'b1;
      res.ev     = evad_pkg::EV_QUIET;
      res.loud   = 1'b0;
      case (func)
         evad_pkg::FUNC_SAMPLE: begin
            // magnitude of a negative sample, -32768 gives 32768
            mag = smp[15] ? (~smp + 16'd1) : smp;
            // a full frame drops further samples but still honors the last mark
            if (acc_count < evad_pkg::MAX_FRAME) begin
               acc_energy = acc_energy + 44'(mag) * 44'(mag);
               acc_count  = acc_count + 14'd1;
            end
            if (!last) begin
               has_result = 1'b0;
            end else begin
               mean = (acc_count != 0) ? 64'(acc_energy) / 64'(acc_count) : 64'd0;
               res.loud   = (mean > 64'(cfg_threshold));
               acc_energy = '0;
               acc_count  = '0;
               // frame end drives the session machine; idle and waiting just report quiet
               case (sess_mode)
                  evad_pkg::MODE_ARMED: begin
                     if (res.loud) begin
                        sess_mode   = evad_pkg::MODE_REC;
                        seg_from_ms = now_ms;
                        loud_at_ms  = now_ms;
                        res.ev      = evad_pkg::EV_SPEECH;
                     end else if (32'(now_ms - rest_from_ms) > 32'(cfg_rest_limit)) begin
                        sess_mode = evad_pkg::MODE_IDLE;
                        res.ev    = evad_pkg::EV_SLEEP;
                     end
                  end
                  evad_pkg::MODE_REC: begin
                     res.ev = evad_pkg::EV_RECORDING;
                     if (res.loud) begin
                        loud_at_ms = now_ms;
                        if (32'(now_ms - seg_from_ms) >= 32'(cfg_max_segment)) begin
                           sess_mode = evad_pkg::MODE_WAIT;
                           res.ev    = evad_pkg::EV_END_LENGTH;
                        end
                     end else if (32'(now_ms - loud_at_ms) > 32'(cfg_max_silence)) begin
                        sess_mode = evad_pkg::MODE_WAIT;
                        res.ev    = evad_pkg::EV_END_SILENCE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         evad_pkg::FUNC_TICK: begin
            now_ms     = now_ms + 32'd1;
            has_result = 1'b0;
         end
         evad_pkg::FUNC_BUTTON: begin
            if (sess_mode == evad_pkg::MODE_IDLE) begin
               sess_mode    = evad_pkg::MODE_ARMED;
               rest_from_ms = now_ms;
               res.ev       = evad_pkg::EV_OPENED;
            end else if (sess_mode == evad_pkg::MODE_ARMED) begin
               sess_mode = evad_pkg::MODE_IDLE;
               res.ev    = evad_pkg::EV_CLOSED;
            end
         end
         default: begin
            // reply done only matters while waiting
            if (sess_mode == evad_pkg::MODE_WAIT) begin
               sess_mode    = evad_pkg::MODE_ARMED;
               rest_from_ms = now_ms;
               res.ev       = evad_pkg::EV_RESUMED;
            end
         end
      endcase
      res.mode = sess_mode;
      if (has_result) pending_events.push_back(res);
   endtask

   // ---------------------------------------------------------------
   // req side: one transfer, with random idle cycles in front of it
   // ---------------------------------------------------------------
   task automatic send_item(input logic [1:0] func, input logic [15:0] smp, input logic last);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = smp;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_session_event(func, smp, last);
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(evad_pkg::FUNC_TICK, 16'($urandom), 1'($urandom));
      end
   endtask

   // a frame of len samples, loud ones at full random scale, quiet ones within +-15
   task automatic send_frame(input int len, input logic make_loud);
      logic [15:0] smp;
      for (int i = 0; i < len; i++) begin
         smp = make_loud ? 16'($urandom) : 16'($urandom_range(0, 30) - 15);
         send_item(evad_pkg::FUNC_SAMPLE, smp, i == len - 1);
      end
   endtask

   // stop offering, let every predicted result arrive, then cover the back stage
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only called with the block drained
   task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         evad_pkg::REG_THRESHOLD:   cfg_threshold   = value;
         evad_pkg::REG_MAX_SEGMENT: cfg_max_segment = value[19:0];
         evad_pkg::REG_MAX_SILENCE: cfg_max_silence = value[19:0];
         default:                   cfg_rest_limit  = value[19:0];
      endcase
   endtask

   // millisecond limits: mostly tiny so sessions cycle, sometimes zero or a very large limit
   function automatic logic [30:0] pick_ms();
      case ($urandom_range(9))
         0:       return 31'd0;
         1:       return 31'd600000;
         default: return 31'($urandom_range(0, 12));
      endcase
   endfunction

   task automatic apply_random_config();
      logic [30:0] thr;
      wait_for_drain();
      case ($urandom_range(3))
         0:       thr = 31'd0;
         1:       thr = 31'd1073741824;
         2:       thr = 31'($urandom_range(0, 5000));
         default: thr = 31'($urandom_range(0, 1073741824));
      endcase
      write_reg(evad_pkg::REG_THRESHOLD, thr);
      write_reg(evad_pkg::REG_MAX_SEGMENT, pick_ms());
      write_reg(evad_pkg::REG_MAX_SILENCE, pick_ms());
      write_reg(evad_pkg::REG_REST_LIMIT, pick_ms());
   endtask

   // ---------------------------------------------------------------
   // test tasks
   // ---------------------------------------------------------------

   // walk the session machine through every mode and event, defaults first
   task automatic test_session_walk();
      // reset registers: frame end while idle, stray reply, open, speech
      send_item(evad_pkg::FUNC_SAMPLE, 16'h7FFF, 1'b1);
      send_item(evad_pkg::FUNC_REPLY, 16'h0000, 1'b0);
      send_item(evad_pkg::FUNC_BUTTON, 16'hFFFF, 1'b1);
      send_item(evad_pkg::FUNC_SAMPLE, 16'h8000, 1'b1);
      // button and reply are ignored while recording
      send_item(evad_pkg::FUNC_BUTTON, 16'h0000, 1'b0);
      send_item(evad_pkg::FUNC_REPLY, 16'h0000, 1'b1);
      wait_for_drain();
      write_reg(evad_pkg::REG_MAX_SEGMENT, 31'd3);
      write_reg(evad_pkg::REG_MAX_SILENCE, 31'd2);
      write_reg(evad_pkg::REG_REST_LIMIT, 31'd2);
      // quiet two-sample frame keeps recording, then silence ends it
      send_item(evad_pkg::FUNC_SAMPLE, 16'd5, 1'b0);
      send_item(evad_pkg::FUNC_SAMPLE, 16'hFFFB, 1'b1);
      send_ticks(3);
      send_item(evad_pkg::FUNC_SAMPLE, 16'd0, 1'b1);
      // waiting: frame end and button are quiet, reply resumes
      send_item(evad_pkg::FUNC_SAMPLE, 16'h7FFF, 1'b1);
      send_item(evad_pkg::FUNC_BUTTON, 16'h1234, 1'b0);
      send_item(evad_pkg::FUNC_REPLY, 16'h0000, 1'b0);
      // armed with no speech past the rest limit goes to sleep
      send_ticks(3);
      send_item(evad_pkg::FUNC_SAMPLE, 16'd1, 1'b1);
      // open, close, open, then a segment that hits the length limit
      send_item(evad_pkg::FUNC_BUTTON, 16'h0000, 1'b0);
      send_item(evad_pkg::FUNC_BUTTON, 16'h0000, 1'b0);
      send_item(evad_pkg::FUNC_BUTTON, 16'h0000, 1'b0);
      send_item(evad_pkg::FUNC_SAMPLE, 16'h8000, 1'b1);
      send_ticks(3);
      send_item(evad_pkg::FUNC_SAMPLE, 16'h7FFF, 1'b1);
      send_item(evad_pkg::FUNC_REPLY, 16'hFFFF, 1'b1);
   endtask

   // mean equal to the threshold is not loud, one above is
   task automatic test_threshold_extremes();
      wait_for_drain();
      write_reg(evad_pkg::REG_THRESHOLD, 31'd0);
      send_item(evad_pkg::FUNC_SAMPLE, 16'd0, 1'b1);
      send_item(evad_pkg::FUNC_SAMPLE, 16'd1, 1'b1);
      wait_for_drain();
      write_reg(evad_pkg::REG_THRESHOLD, 31'd1073741824);
      send_item(evad_pkg::FUNC_SAMPLE, 16'h8000, 1'b1);
      wait_for_drain();
      write_reg(evad_pkg::REG_THRESHOLD, 31'd1073741823);
      send_item(evad_pkg::FUNC_SAMPLE, 16'h8000, 1'b1);
   endtask

   // one full frame at the largest sum, then dropped zero samples that must not count
   task automatic test_frame_saturation();
      wait_for_drain();
      write_reg(evad_pkg::REG_THRESHOLD, 31'd1073741823);
      for (int i = 0; i < evad_pkg::MAX_FRAME; i++) begin
         send_item(evad_pkg::FUNC_SAMPLE, 16'h8000, 1'b0);
      end
      for (int i = 0; i < 4; i++) send_item(evad_pkg::FUNC_SAMPLE, 16'd0, i == 3);
   endtask

   // rsp held off long enough to fill the result queue while req keeps offering
   task automatic test_backpressure();
      hold_requests++;
      for (int i = 0; i < 48; i++) begin
         if (i % 3 == 2) send_item(evad_pkg::FUNC_REPLY, 16'($urandom), 1'($urandom));
         else            send_item(evad_pkg::FUNC_BUTTON, 16'($urandom), 1'($urandom));
      end
   endtask

   // session-shaped random traffic with a new register set every chunk
   task automatic test_random_traffic(input int n_items);
      int start;
      int next_cfg;
      int pick;
      start    = items_sent;
      next_cfg = items_sent;
      while (items_sent - start < n_items) begin
         if (items_sent >= next_cfg) begin
            apply_random_config();
            next_cfg = items_sent + 150;
         end
         pick = $urandom_range(99);
         if (pick < 38) begin
            send_frame(($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6),
                       1'($urandom));
         end else if (pick < 58) begin
            send_ticks($urandom_range(1, 8));
         end else if (pick < 74) begin
            send_item(evad_pkg::FUNC_BUTTON, 16'($urandom), 1'($urandom));
         end else if (pick < 88) begin
            send_item(evad_pkg::FUNC_REPLY, 16'($urandom), 1'($urandom));
         end else begin
            // noise: any kind, any sample, any frame mark
            send_item(2'($urandom), 16'($urandom), 1'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // rsp side: random stalls, plus the long hold when a test asks for it
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker: each rsp transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result transfer, tdata %h", rsp_tdata);
            failures++;
         end else begin
            head_event = pending_events.pop_front();
            if (rsp_tdata[3:0] !== head_event.ev) begin
               $error("event_res mismatch: expected %0d, got %0d", head_event.ev,
                      rsp_tdata[3:0]);
               failures++;
            end
            if (rsp_tdata[4] !== head_event.loud) begin
               $error("loud mismatch: expected %0d, got %0d", head_event.loud, rsp_tdata[4]);
               failures++;
            end
            if (rsp_tdata[6:5] !== head_event.mode) begin
               $error("mode mismatch: expected %0d, got %0d", head_event.mode,
                      rsp_tdata[6:5]);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[energy_vad_endpoint_detector_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = evad_pkg::FUNC_SAMPLE;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = evad_pkg::REG_THRESHOLD;
      csr_wr_data = '0;
      // predictor starts from the reset state
      sess_mode       = evad_pkg::MODE_IDLE;
      now_ms          = '0;
      rest_from_ms    = '0;
      seg_from_ms     = '0;
      loud_at_ms      = '0;
      acc_energy      = '0;
      acc_count       = '0;
      cfg_threshold   = 31'd2000;
      cfg_max_segment = 20'd10000;
      cfg_max_silence = 20'd1000;
      cfg_rest_limit  = 20'd30000;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 15;
      recv_idle_pct = 84;
      test_session_walk();
      test_threshold_extremes();
      test_random_traffic(620);

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 84;
      recv_idle_pct = 15;
      test_random_traffic(620);

      // no idling at all
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_frame_saturation();
      test_backpressure();
      test_random_traffic(620);

      wait_for_drain();
      if (failures == 0 && pending_events.size() == 0) begin
         $display("[energy_vad_endpoint_detector_unit] OK");
      end else begin
         $display("[energy_vad_endpoint_detector_unit] ERROR");
      end
      $finish;
   end

endmodule
